// ===== design/bgc_pkg.sv =====
// Package: shared types, constants and column operators for the grid cleanup block.
`default_nettype none
package bgc_pkg;

  localparam int COL_W = 64;
  localparam int IDX_W = 6;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Which result of the item in the stage is being formed.
  typedef enum logic [1:0] {
    PH_OLD,   // column c-2
    PH_PREV,  // column c-1, last column only
    PH_CUR    // column c, last column only
  } phase_t;

  typedef struct packed {
    idx_t column_index;
    col_t floor_bits;
    col_t wall_bits;
    logic frame_last;
  } bgc_result_t;

  // Up/down neighbor spread inside the grid.
  function automatic col_t vert(input col_t v, input col_t mask);
    return ((v << 1) | (v >> 1)) & mask;
  endfunction

  // Floor kept only where an orthogonal neighbor is floor.
  function automatic col_t clean_col(input col_t left, input col_t mid,
                                     input col_t right, input col_t mask);
    return mid & (left | right | vert(mid, mask)) & mask;
  endfunction

  // Non-floor cells with floor among their eight neighbors.
  function automatic col_t ring_col(input col_t left, input col_t mid,
                                    input col_t right, input col_t mask);
    col_t u;
    col_t d;
    u = left | mid | right;
    d = (u | vert(u, mask)) & mask;
    return d & ~mid;
  endfunction

endpackage
`default_nettype wire

// ===== design/bgc_if.sv =====
// Interfaces: column input channel and result output channel.
`default_nettype none
interface bgc_col_if;
  logic                valid;
  logic                ready;
  logic [63:0]         column_bits;

  modport source (output valid, output column_bits, input ready);
  modport sink   (input valid, input column_bits, output ready);
endinterface

interface bgc_res_if;
  logic                valid;
  logic                ready;
  logic [5:0]          column_index;
  logic [63:0]         floor_bits;
  logic [63:0]         wall_bits;
  logic                frame_last;

  modport source (output valid, output column_index, output floor_bits,
                  output wall_bits, output frame_last, input ready);
  modport sink   (input valid, input column_index, input floor_bits,
                  input wall_bits, input frame_last, output ready);
endinterface
`default_nettype wire

// ===== design/binary_grid_cleanup_and_border_mark.sv =====
// Top level: streaming binary grid cleanup and border marking, one column per transfer.
// A square grid of GRID_SIDE x GRID_SIDE cells arrives one column per input
// transfer, bit y of column_bits being row y; rows at GRID_SIDE and above are
// ignored and come out zero. A floor cell survives if one of its four
// orthogonal neighbors is floor in the raw map; a non-floor cell is marked
// wall if any of its eight neighbors is surviving floor. The result for
// column c is formed while column c+2 sits in the input stage, so columns 0
// and 1 produce nothing on their own; the last column (GRID_SIDE-1) releases
// three results (c-2, c-1, c) and the last carries frame_last. After that the
// block starts a fresh grid at column 0. Throughput is one column per clock
// while the sink is ready, apart from the last column: the input stage register
// feeds a combinational kernel whose result lands in one output register. The
// last column holds the stage until its three results are taken, one at a time,
// because the output register takes one result per cycle while the sink is ready;
// a stalled sink holds the stage. The result for column c passes from the stage,
// where column c+2 sits, into the output register, and a stalled sink can hold it
// in either. Input ready is low while rst is high.
`default_nettype none
module binary_grid_cleanup_and_border_mark #(
  parameter int GRID_SIDE = 64
) (
  input  wire        clk,
  input  wire        rst,
  bgc_col_if.sink    columns,
  bgc_res_if.source  results
);
  import bgc_pkg::*;

  localparam idx_t LAST_IDX = idx_t'(GRID_SIDE - 1);

  // input stage
  logic        stage_valid;
  col_t        col_q;
  idx_t        col_cnt;      // index of the column held in the stage
  phase_t      phase;

  // history of the frame
  col_t        raw_back_one;
  col_t        raw_back_two;
  col_t        clean_back_two;
  col_t        clean_back_three;

  col_t        col_masked;
  col_t        clean_prev;
  bgc_result_t result;

  logic        take;
  logic        is_last;
  logic        has_result;
  logic        emit;
  logic        stage_done;
  logic        accept;

  bgc_kernel #(
    .GRID_SIDE (GRID_SIDE)
  ) u_kernel (
    .col_raw          (col_q),
    .col_idx          (col_cnt),
    .phase            (phase),
    .raw_back_one     (raw_back_one),
    .raw_back_two     (raw_back_two),
    .clean_back_two   (clean_back_two),
    .clean_back_three (clean_back_three),
    .col_masked       (col_masked),
    .clean_prev       (clean_prev),
    .result           (result)
  );

  bgc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (result),
    .take      (take),
    .res       (results)
  );

  assign is_last    = (col_cnt == LAST_IDX);
  // phase PH_OLD needs two columns of history; later phases only on the last column
  assign has_result = stage_valid && (col_cnt >= idx_t'(2) || phase != PH_OLD);
  assign emit       = has_result && take;
  assign stage_done = stage_valid && (!has_result || take) &&
                      (!is_last || phase == PH_CUR);
  assign columns.ready = !rst && (!stage_valid || stage_done);
  assign accept     = columns.valid && columns.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid      <= 1'b0;
      phase            <= PH_OLD;
      col_cnt          <= '0;
      raw_back_one     <= '0;
      raw_back_two     <= '0;
      clean_back_two   <= '0;
      clean_back_three <= '0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (stage_done) begin
        stage_valid <= 1'b0;
      end

      if (stage_done) begin
        phase <= PH_OLD;
      end else if (emit && is_last) begin
        unique case (phase)
          PH_OLD:  phase <= PH_PREV;
          PH_PREV: phase <= PH_CUR;
          default: phase <= PH_OLD;
        endcase
      end

      if (stage_done) begin
        if (is_last) begin
          // end of frame: clear history for the next grid
          col_cnt          <= '0;
          raw_back_one     <= '0;
          raw_back_two     <= '0;
          clean_back_two   <= '0;
          clean_back_three <= '0;
        end else begin
          col_cnt          <= col_cnt + idx_t'(1);
          raw_back_two     <= raw_back_one;
          raw_back_one     <= col_masked;
          clean_back_three <= clean_back_two;
          clean_back_two   <= clean_prev;
        end
      end
    end
    if (accept) begin
      col_q <= columns.column_bits;
    end
  end

`ifndef ASSERT_OFF
  a_last_tag: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.frame_last |-> results.column_index == LAST_IDX)
    else $error("frame_last on a column other than the last");

  a_phase_only_last: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !is_last |-> phase == PH_OLD)
    else $error("extra result phase outside the last column");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    stage_done && is_last |=> col_cnt == '0 && phase == PH_OLD)
    else $error("frame did not restart after the last column");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> results.valid)
    else $error("emitted result not presented");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    stage_valid && col_cnt < idx_t'(2) |-> !emit)
    else $error("result emitted before two columns of history");
`endif

endmodule
`default_nettype wire

// ===== design/bgc_kernel.sv =====
// Column kernel: cleanup and border mark for one result from the stored columns.
`default_nettype none
module bgc_kernel #(
  parameter int GRID_SIDE = 64
) (
  input  wire  bgc_pkg::col_t       col_raw,
  input  wire  bgc_pkg::idx_t       col_idx,
  input  wire  bgc_pkg::phase_t     phase,
  input  wire  bgc_pkg::col_t       raw_back_one,
  input  wire  bgc_pkg::col_t       raw_back_two,
  input  wire  bgc_pkg::col_t       clean_back_two,
  input  wire  bgc_pkg::col_t       clean_back_three,
  output bgc_pkg::col_t             col_masked,
  output bgc_pkg::col_t             clean_prev,
  output bgc_pkg::bgc_result_t      result
);
  import bgc_pkg::*;

  localparam col_t ROW_MASK = {COL_W{1'b1}} >> (COL_W - GRID_SIDE);

  col_t clean_cur;

  assign col_masked = col_raw & ROW_MASK;
  assign clean_prev = clean_col(raw_back_two, raw_back_one, col_masked, ROW_MASK);
  assign clean_cur  = clean_col(raw_back_one, col_masked, '0, ROW_MASK);

  always_comb begin
    unique case (phase)
      PH_OLD: begin
        result.column_index = col_idx - idx_t'(2);
        result.floor_bits   = clean_back_two;
        result.wall_bits    = ring_col(clean_back_three, clean_back_two, clean_prev,
                                       ROW_MASK);
        result.frame_last   = 1'b0;
      end
      PH_PREV: begin
        result.column_index = col_idx - idx_t'(1);
        result.floor_bits   = clean_prev;
        result.wall_bits    = ring_col(clean_back_two, clean_prev, clean_cur, ROW_MASK);
        result.frame_last   = 1'b0;
      end
      PH_CUR: begin
        result.column_index = col_idx;
        result.floor_bits   = clean_cur;
        result.wall_bits    = ring_col(clean_prev, clean_cur, '0, ROW_MASK);
        result.frame_last   = 1'b1;
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/bgc_out_reg.sv =====
// Output register: holds one result until the sink takes it.
`default_nettype none
module bgc_out_reg (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       push,
  input  wire  bgc_pkg::bgc_result_t push_data,
  output logic                      take,
  bgc_res_if.source                 res
);
  import bgc_pkg::*;

  logic        valid_q;
  bgc_result_t data_q;

  // free when empty or being drained this cycle
  assign take = !valid_q || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= push;
    end
    if (take && push) begin
      data_q <= push_data;
    end
  end

  assign res.valid        = valid_q;
  assign res.column_index = data_q.column_index;
  assign res.floor_bits   = data_q.floor_bits;
  assign res.wall_bits    = data_q.wall_bits;
  assign res.frame_last   = data_q.frame_last;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the grid cleanup block: directed column table, random columns, scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import bgc_pkg::*;

  localparam int SIDE        = 64;
  localparam int TOTAL_ITEMS = 350;
  localparam int DIR_N       = 14;
  localparam int HOLD_AT     = 150;  // item at which the sink holds off
  localparam int PAUSE_AT    = 260;  // item before which the source drains everything
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 200000;

  localparam col_t ROW_MASK = {COL_W{1'b1}} >> (COL_W - SIDE);
  localparam col_t ALL1     = {COL_W{1'b1}};
  localparam col_t ALL0     = {COL_W{1'b0}};

  typedef struct packed {
    col_t        bits;
    logic        typed;  // exp holds the single result this column releases
    bgc_result_t exp;
  } plan_row_t;

  localparam bgc_result_t NO_EXP = '0;

  // Starts right after reset, so row n is column n of the first grid.
  localparam plan_row_t PLAN [DIR_N] = '{
    '{ALL0, 1'b0, NO_EXP},
    '{ALL0, 1'b0, NO_EXP},
    '{ALL1, 1'b1, '{6'd0, ALL0, ALL0, 1'b0}},
    '{ALL1, 1'b1, '{6'd1, ALL0, ALL1, 1'b0}},   // full wall beside a solid block
    '{ALL1, 1'b1, '{6'd2, ALL1, ALL0, 1'b0}},
    '{ALL0, 1'b1, '{6'd3, ALL1, ALL0, 1'b0}},
    '{ALL0, 1'b1, '{6'd4, ALL1, ALL0, 1'b0}},
    '{64'h8000_0000_0000_0000, 1'b1, '{6'd5, ALL0, ALL1, 1'b0}},
    '{ALL0, 1'b1, '{6'd6, ALL0, ALL0, 1'b0}},   // top-edge isolated cell gone
    '{64'h1, 1'b1, '{6'd7, ALL0, ALL0, 1'b0}},
    '{ALL0, 1'b1, '{6'd8, ALL0, ALL0, 1'b0}},
    '{64'h3, 1'b1, '{6'd9, ALL0, ALL0, 1'b0}},   // vertical pair on bottom edge
    '{ALL0, 1'b1, '{6'd10, ALL0, 64'h7, 1'b0}},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{6'd11, 64'h3, 64'h4, 1'b0}}
  };

  // Extra directed columns checked by the predictor only.
  localparam col_t EXTRA [11] = '{
    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'hC000_0000_0000_0000,
    64'hFFFF_FFFF_0000_0000, 64'h8000_0000_0000_0001, ALL1,
    64'hDEAD_BEEF_F00D_CAFE, ALL0, 64'h0123_4567_89AB_CDEF,
    64'hFEDC_BA98_7654_3210, 64'h4000_0000_0000_0002
  };

  logic clk;
  logic rst;

  bgc_col_if col_ch ();
  bgc_res_if res_ch ();

  binary_grid_cleanup_and_border_mark #(.GRID_SIDE(SIDE)) uut (
    .clk     (clk),
    .rst     (rst),
    .columns (col_ch),
    .results (res_ch)
  );

  // Predictor state: raw columns c-1, c-2, cleaned columns c-2, c-3, position.
  col_t        raw_m1, raw_m2, kept_m2, kept_m3;
  logic [6:0]  col_pos;
  bgc_result_t awaited_cols [$];

  int   errors;
  int   cycle_count;
  logic hold_ask;

  function automatic col_t up_down(input col_t v);
    return ((v << 1) | (v >> 1)) & ROW_MASK;
  endfunction

  // Floor that has an orthogonal floor neighbor in the raw map.
  function automatic col_t survivors(input col_t l, input col_t m, input col_t r);
    return m & (l | r | up_down(m)) & ROW_MASK;
  endfunction

  // Non-floor cells touching surviving floor, eight directions.
  function automatic col_t halo(input col_t l, input col_t m, input col_t r);
    col_t u;
    u = l | m | r;
    return (u | up_down(u)) & ROW_MASK & ~m;
  endfunction

  function automatic bgc_result_t make_res(input logic [6:0] idx, input col_t fl,
                                           input col_t wl, input logic last);
    bgc_result_t res;
    res.column_index = idx[IDX_W-1:0];
    res.floor_bits   = fl;
    res.wall_bits    = wl;
    res.frame_last   = last;
    return res;
  endfunction

  // Appends one result to the tail of the scoreboard.
  task automatic add_awaited(input bgc_result_t r);
    awaited_cols = {awaited_cols, r};
  endtask

  // Advances the grid state by one column and queues what it releases.
  task automatic grid_advance(input col_t bits);
    col_t r, kept_m1, kept_now;
    r = bits & ROW_MASK;
    kept_m1 = survivors(raw_m2, raw_m1, r);
    if (col_pos >= 7'd2) begin
      add_awaited(make_res(col_pos - 7'd2, kept_m2,
                           halo(kept_m3, kept_m2, kept_m1), 1'b0));
    end
    if (col_pos >= 7'(SIDE - 1)) begin
      // last column flushes c-1 and c, then a fresh grid starts
      kept_now = survivors(raw_m1, r, ALL0);
      add_awaited(make_res(col_pos - 7'd1, kept_m1,
                           halo(kept_m2, kept_m1, kept_now), 1'b0));
      add_awaited(make_res(col_pos, kept_now,
                           halo(kept_m1, kept_now, ALL0), 1'b1));
      raw_m1  = ALL0;
      raw_m2  = ALL0;
      kept_m2 = ALL0;
      kept_m3 = ALL0;
      col_pos = '0;
    end else begin
      kept_m3 = kept_m2;
      kept_m2 = kept_m1;
      raw_m2  = raw_m1;
      raw_m1  = r;
      col_pos = col_pos + 7'd1;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  // Mix of densities so isolated cells, pairs and solid runs all show up.
  function automatic col_t draw_column();
    col_t a, b, c;
    int   mode;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    mode = $urandom_range(0, 7);
    case (mode)
      0: return a;
      1: return a & b & c;
      2: return a & b;
      3: return a | b;
      4: return ALL0;
      5: return ALL1;
      6: return col_t'(1) << $urandom_range(0, COL_W - 1);
      default: return a & (a >> 1) & ~(b & c);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Source side: directed table, extra columns, then random columns; end of run lives here.
  initial begin
    col_t bits;
    int   gap;
    logic calm;
    logic pause;
    rst = 1'b1;
    col_ch.valid = 1'b0;
    col_ch.column_bits = '0;
    errors = 0;
    cycle_count = 0;
    hold_ask = 1'b0;
    raw_m1 = '0;
    raw_m2 = '0;
    kept_m2 = '0;
    kept_m3 = '0;
    col_pos = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < TOTAL_ITEMS; n++) begin
      if (n < DIR_N) bits = PLAN[n].bits;
      else if (n < DIR_N + 11) bits = EXTRA[n - DIR_N];
      else bits = draw_column();
      calm  = ((n / 40) % 3 == 1);
      gap   = calm ? 0 : $urandom_range(0, 12);
      pause = (n == PAUSE_AT);
      if (n == HOLD_AT) hold_ask = 1'b1;
      if (pause || gap > 0) begin
        col_ch.valid <= 1'b0;
        // pause: let the block drain every pending result first
        if (pause) begin
          do @(posedge clk); while (awaited_cols.size() != 0);
        end
        repeat (gap) @(posedge clk);
      end
      col_ch.valid <= 1'b1;
      col_ch.column_bits <= bits;
      do @(posedge clk); while (!col_ch.ready);
      grid_advance(bits);
      if (n < DIR_N && PLAN[n].typed) begin
        awaited_cols[awaited_cols.size() - 1] = PLAN[n].exp;
      end
    end
    col_ch.valid <= 1'b0;
    while (awaited_cols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Sink side: random back-pressure, one long hold-off, field-by-field check.
  initial begin
    bgc_result_t want;
    int   stall;
    int   got;
    logic held;
    res_ch.ready = 1'b0;
    got = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      held = hold_ask;
      if (held) stall = HOLD_CYCLES;
      else if ((got / 30) % 3 == 2) stall = 0;
      else stall = $urandom_range(0, 12);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        if (held) hold_ask = 1'b0;
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got++;
      if (awaited_cols.size() == 0) begin
        report_mismatch($sformatf("unexpected result for column %0d",
                                  res_ch.column_index));
      end else begin
        want = awaited_cols.pop_front();
        if (res_ch.column_index !== want.column_index)
          report_mismatch($sformatf("column_index %0d, want %0d",
                                    res_ch.column_index, want.column_index));
        if (res_ch.floor_bits !== want.floor_bits)
          report_mismatch($sformatf("col %0d floor_bits %h, want %h", want.column_index,
                                    res_ch.floor_bits, want.floor_bits));
        if (res_ch.wall_bits !== want.wall_bits)
          report_mismatch($sformatf("col %0d wall_bits %h, want %h", want.column_index,
                                    res_ch.wall_bits, want.wall_bits));
        if (res_ch.frame_last !== want.frame_last)
          report_mismatch($sformatf("col %0d frame_last %b, want %b", want.column_index,
                                    res_ch.frame_last, want.frame_last));
      end
    end
  end

endmodule
`default_nettype wire
